### rtl/mh64_pkg.sv
// Shared constants and types for the 64-bit murmur hash engine.
package mh64_pkg;

    // Mixing multiplier and shift amount
    localparam logic [63:0] MIX_MUL   = 64'hc6a4a7935bd1e995;
    localparam int unsigned MIX_SHIFT = 47;

    // Byte counts
    localparam logic [3:0] BYTES_FULL = 4'd8;
    localparam logic [3:0] BYTES_NONE = 4'd0;

    // Sequencer states: each product state owns one pass of the shared multiplier
    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_K1,
        S_K2,
        S_H,
        S_FIN,
        S_EMIT
    } t_state;

    // Multiplier partial-product steps
    typedef enum logic [1:0] {
        STEP_LO,
        STEP_HL,
        STEP_LH
    } t_mul_step;

    // Status from the shared multiplier back to the sequencer
    typedef struct packed {
        logic        done;
        logic [63:0] prod;
    } t_mul_stat;

endpackage

### rtl/mh64_mul.sv
// Iterative 64-bit by MIX_MUL multiplier (low 64 bits) on one 32x32 multiplier.
module mh64_mul import mh64_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_run,
    input  logic [63:0] i_a,
    output t_mul_stat   o_stat
);

    t_mul_step   r_step, n_step;
    logic [63:0] r_acc, n_acc;
    logic [31:0] op_a, op_b;
    logic [63:0] part;

    // Operand selection for the current partial product
    always_comb begin
        case (r_step)
            STEP_LO: begin
                op_a = i_a[31:0];
                op_b = MIX_MUL[31:0];
            end
            STEP_HL: begin
                op_a = i_a[63:32];
                op_b = MIX_MUL[31:0];
            end
            STEP_LH: begin
                op_a = i_a[31:0];
                op_b = MIX_MUL[63:32];
            end
            default: begin
                op_a = i_a[31:0];
                op_b = MIX_MUL[31:0];
            end
        endcase
    end

    assign part = op_a * op_b;

    // Step sequencing and accumulation; cross terms only touch the upper half
    always_comb begin
        n_step = r_step;
        n_acc  = r_acc;
        if (!i_run) begin
            n_step = STEP_LO;
        end else begin
            case (r_step)
                STEP_LO: begin
                    n_acc  = part;
                    n_step = STEP_HL;
                end
                STEP_HL: begin
                    n_acc  = {r_acc[63:32] + part[31:0], r_acc[31:0]};
                    n_step = STEP_LH;
                end
                STEP_LH: begin
                    n_step = STEP_LO;
                end
                default: begin
                    n_step = STEP_LO;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_LO;
        end else begin
            r_step <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    // Final product is ready during the last step
    assign o_stat.done = i_run && (r_step == STEP_LH);
    assign o_stat.prod = {r_acc[63:32] + part[31:0], r_acc[31:0]};

endmodule

### rtl/murmur_hash_64bit.sv
// Top level of the 64-bit murmur hash engine: sequencer, state and output register.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+----------------------------------------
//  in      | input     | i_in_valid / o_in_stall   | i_data_word, i_byte_count,
//          |           |                           | i_total_length, i_first_word, i_last_word
//  out     | output    | o_out_valid / i_out_stall | o_hash_value
//  cfg     | input     | i_cfg_we                  | i_cfg_data (hash seed)
//
// Each 64-bit product runs the LO, HL and LH steps on the shared 32x32 multiplier.
// A full word is accepted, then runs the K1, K2 and H products; a tail word runs only H,
// an empty non-final word is only accepted; first words add INIT, last words FIN and EMIT.
// o_in_stall is high while a transaction is being processed and during reset.
// The result sits in an output register; a stalled output only holds the emit step.
module murmur_hash_64bit import mh64_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [63:0] i_data_word,
    input  logic [3:0]  i_byte_count,
    input  logic [30:0] i_total_length,
    input  logic        i_first_word,
    input  logic        i_last_word,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [63:0] o_hash_value,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_data
);

    t_state      r_state, n_state;
    logic [31:0] r_seed;
    logic [63:0] r_hash, n_hash;
    logic [63:0] r_opnd, n_opnd;
    logic [63:0] r_word, n_word;
    logic [3:0]  r_cnt, n_cnt;
    logic        r_last, n_last;
    logic        r_out_valid, n_out_valid;
    logic [63:0] r_out_data, n_out_data;

    logic        in_acc;
    logic        out_free;
    logic        mul_run;
    t_mul_stat   mul_stat;
    logic [3:0]  in_cnt;
    logic [63:0] init_hash;

    // Where a word goes once the running hash is known
    function automatic t_state f_dispatch(input logic [3:0] cnt, input logic last);
        t_state s;
        if (cnt == BYTES_FULL) begin
            s = S_K1;
        end else if (cnt != BYTES_NONE) begin
            s = S_H;
        end else if (last) begin
            s = S_FIN;
        end else begin
            s = S_IDLE;
        end
        return s;
    endfunction

    // First multiplier operand for a dispatched word
    function automatic logic [63:0] f_dispatch_opnd(input logic [3:0] cnt,
                                                   input logic [63:0] word,
                                                   input logic [63:0] h);
        logic [63:0] mask;
        logic [63:0] opnd;
        for (int i = 0; i < 8; i++) begin
            mask[8*i +: 8] = (4'(i) < cnt) ? 8'hff : 8'h00;
        end
        if (cnt == BYTES_FULL) begin
            opnd = word;
        end else if (cnt != BYTES_NONE) begin
            opnd = h ^ (word & mask);
        end else begin
            opnd = h ^ (h >> MIX_SHIFT);
        end
        return opnd;
    endfunction

    assign o_in_stall = (r_state != S_IDLE) || !i_rst_n;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign in_cnt     = (i_byte_count > BYTES_FULL) ? BYTES_FULL : i_byte_count;
    assign init_hash  = {32'd0, r_seed} ^ mul_stat.prod;

    assign mul_run = (r_state == S_INIT) || (r_state == S_K1) || (r_state == S_K2)
                  || (r_state == S_H) || (r_state == S_FIN);

    mh64_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_run   (mul_run),
        .i_a     (r_opnd),
        .o_stat  (mul_stat)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = i_first_word ? S_INIT : f_dispatch(in_cnt, i_last_word);
                end
            end
            S_INIT: begin
                if (mul_stat.done) begin
                    n_state = f_dispatch(r_cnt, r_last);
                end
            end
            S_K1: begin
                if (mul_stat.done) begin
                    n_state = S_K2;
                end
            end
            S_K2: begin
                if (mul_stat.done) begin
                    n_state = S_H;
                end
            end
            S_H: begin
                if (mul_stat.done) begin
                    n_state = r_last ? S_FIN : S_IDLE;
                end
            end
            S_FIN: begin
                if (mul_stat.done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Datapath updates per state
    always_comb begin
        n_hash      = r_hash;
        n_opnd      = r_opnd;
        n_word      = r_word;
        n_cnt       = r_cnt;
        n_last      = r_last;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_data  = r_out_data;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_word = i_data_word;
                    n_cnt  = in_cnt;
                    n_last = i_last_word;
                    if (i_first_word) begin
                        n_opnd = {33'd0, i_total_length};
                    end else begin
                        n_opnd = f_dispatch_opnd(in_cnt, i_data_word, r_hash);
                    end
                end
            end
            S_INIT: begin
                if (mul_stat.done) begin
                    n_hash = init_hash;
                    n_opnd = f_dispatch_opnd(r_cnt, r_word, init_hash);
                end
            end
            S_K1: begin
                if (mul_stat.done) begin
                    n_opnd = mul_stat.prod ^ (mul_stat.prod >> MIX_SHIFT);
                end
            end
            S_K2: begin
                if (mul_stat.done) begin
                    n_opnd = r_hash ^ mul_stat.prod;
                end
            end
            S_H: begin
                if (mul_stat.done) begin
                    n_hash = mul_stat.prod;
                    n_opnd = mul_stat.prod ^ (mul_stat.prod >> MIX_SHIFT);
                end
            end
            S_FIN: begin
                if (mul_stat.done) begin
                    n_opnd = mul_stat.prod;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_opnd ^ (r_opnd >> MIX_SHIFT);
                end
            end
            default: begin
                n_out_valid = r_out_valid && i_out_stall;
            end
        endcase
    end

    // Control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_hash      <= 64'd0;
            r_seed      <= 32'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_hash      <= n_hash;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_seed <= i_cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_opnd     <= n_opnd;
        r_word     <= n_word;
        r_cnt      <= n_cnt;
        r_last     <= n_last;
        r_out_data <= n_out_data;
    end

    assign o_out_valid  = r_out_valid;
    assign o_hash_value = r_out_data;

endmodule

### rtl/mh64_checker.sv
// Port-level checks for the murmur hash engine, bound to the top level.
module mh64_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        i_first_word,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [63:0] o_hash_value
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_hash_value))
        else $error("result changed while stalled");

    // Reset empties the output register
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // A first-word transaction always starts a multiply, so input stalls next
    a_first_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_first_word |=> o_in_stall)
        else $error("first word accepted without seed multiply");

    // A result only appears out of the busy emit step
    a_emit_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result emitted while idle");

endmodule

bind murmur_hash_64bit mh64_checker u_mh64_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .i_first_word (i_first_word),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_hash_value (o_hash_value)
);

### sim/testbench.sv
// Self-checking testbench for the streaming 64-bit murmur hash engine.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import mh64_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned SETTLE_TICKS = 30;
    localparam int unsigned HOLD_TICKS   = 400;
    localparam int unsigned MAX_REPORTS  = 10;

    // One input transaction plus the idle cycles the sender inserts before it
    typedef struct {
        logic [63:0] data;
        logic [3:0]  nbytes;
        logic [30:0] key_len;
        logic        first;
        logic        last;
        int unsigned gap;
    } key_word_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [63:0] i_data_word = '0;
    logic [3:0]  i_byte_count = '0;
    logic [30:0] i_total_length = '0;
    logic        i_first_word = 1'b0;
    logic        i_last_word = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [63:0] o_hash_value;
    logic        i_cfg_we = 1'b0;
    logic [31:0] i_cfg_data = '0;

    key_word_t   key_words[$];
    logic [63:0] expected_hashes[$];
    logic [63:0] running_hash_model = '0;
    logic [31:0] seed_model = '0;
    int unsigned words_queued = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;
    int unsigned tx_idle = 0;
    int unsigned rx_delay = 0;
    int unsigned hold_left = 0;
    bit          rx_paced = 1'b1;
    logic        hold_request = 1'b0;
    logic        hold_used = 1'b0;

    murmur_hash_64bit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_data_word    (i_data_word),
        .i_byte_count   (i_byte_count),
        .i_total_length (i_total_length),
        .i_first_word   (i_first_word),
        .i_last_word    (i_last_word),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_hash_value   (o_hash_value),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    function automatic int unsigned pick_gap(input bit paced);
        return paced ? $urandom_range(0, 5) : 0;
    endfunction

    // Update the hash model with one accepted word; queue the finished hash on the last word
    task automatic absorb_word(input logic [63:0] data, input logic [3:0] nbytes,
                               input logic [30:0] key_len, input logic first,
                               input logic last);
        logic [63:0] h;
        logic [63:0] k;
        logic [63:0] mask;
        h = first ? ({32'd0, seed_model} ^ (64'(key_len) * MIX_MUL)) : running_hash_model;
        if (nbytes >= BYTES_FULL) begin
            // counts above eight mix as a full word
            k = data * MIX_MUL;
            k = k ^ (k >> MIX_SHIFT);
            k = k * MIX_MUL;
            h = h ^ k;
            h = h * MIX_MUL;
        end else if (nbytes != BYTES_NONE) begin
            // tail: valid low bytes only
            mask = (64'd1 << (8 * nbytes)) - 64'd1;
            h = h ^ (data & mask);
            h = h * MIX_MUL;
        end
        running_hash_model = h;
        if (last) begin
            h = h ^ (h >> MIX_SHIFT);
            h = h * MIX_MUL;
            h = h ^ (h >> MIX_SHIFT);
            expected_hashes.push_back(h);
        end
    endtask

    task automatic push_word(input logic [63:0] data, input logic [3:0] nbytes,
                             input logic [30:0] key_len, input logic first,
                             input logic last, input int unsigned gap);
        key_word_t w;
        w.data    = data;
        w.nbytes  = nbytes;
        w.key_len = key_len;
        w.first   = first;
        w.last    = last;
        w.gap     = gap;
        key_words.push_back(w);
        words_queued++;
    endtask

    // Well-formed key of the given length split into little-endian words
    task automatic push_key(input int unsigned key_bytes, input logic [30:0] len_field,
                            input bit paced);
        int unsigned left;
        int unsigned take;
        bit          head;
        left = key_bytes;
        head = 1'b1;
        if (left == 0)
            push_word(rand_word(), BYTES_NONE, len_field, 1'b1, 1'b1, pick_gap(paced));
        while (left > 0) begin
            take = (left > 8) ? 8 : left;
            left = left - take;
            push_word(rand_word(), 4'(take), len_field, head, left == 0, pick_gap(paced));
            head = 1'b0;
        end
    endtask

    task automatic random_keys(input int unsigned word_target);
        int unsigned stop_at;
        int unsigned key_bytes;
        logic [30:0] len_field;
        bit          paced;
        stop_at = words_queued + word_target;
        while (words_queued < stop_at) begin
            paced = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 99) < 85) begin
                key_bytes = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 64)
                                                        : $urandom_range(0, 24);
                // occasionally a length field that disagrees with the key
                len_field = ($urandom_range(0, 19) == 0) ? 31'($urandom) : 31'(key_bytes);
                push_key(key_bytes, len_field, paced);
            end else begin
                // noise: any field combination
                push_word(rand_word(), 4'($urandom_range(0, 15)), 31'($urandom),
                          1'($urandom), 1'($urandom), pick_gap(paced));
            end
        end
    endtask

    // Block until every queued word is accepted and every hash has come back
    task automatic wait_drained();
        do
            @(negedge i_clk);
        while (key_words.size() != 0 || i_in_valid || expected_hashes.size() != 0);
        repeat (SETTLE_TICKS) @(negedge i_clk);
    endtask

    // Seed write while the engine is idle
    task automatic load_seed(input logic [31:0] seed);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= seed;
        seed_model = seed;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] exp_hash,
                                   input logic [63:0] got_hash);
        if (mismatch_count < MAX_REPORTS)
            $display("tb: %s hash expected %h got %h at cycle %0d",
                     what, exp_hash, got_hash, cycle_count);
        mismatch_count++;
    endtask

    // Driver: present queued words, record each accepted transaction in the model
    always @(posedge i_clk) begin
        key_word_t w;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            tx_idle    <= 0;
        end else begin
            if (i_in_valid && !o_in_stall)
                absorb_word(i_data_word, i_byte_count, i_total_length, i_first_word,
                            i_last_word);
            if (!i_in_valid || !o_in_stall) begin
                if (key_words.size() == 0) begin
                    i_in_valid <= 1'b0;
                end else if (tx_idle < key_words[0].gap) begin
                    i_in_valid <= 1'b0;
                    tx_idle    <= tx_idle + 1;
                end else begin
                    w = key_words.pop_front();
                    i_data_word    <= w.data;
                    i_byte_count   <= w.nbytes;
                    i_total_length <= w.key_len;
                    i_first_word   <= w.first;
                    i_last_word    <= w.last;
                    i_in_valid     <= 1'b1;
                    tx_idle        <= 0;
                end
            end
        end
    end

    // Monitor: check each hash, then decide the stall for the next cycle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_hashes.size() == 0)
                    report_mismatch("unexpected", '0, o_hash_value);
                else if (expected_hashes[0] !== o_hash_value)
                    report_mismatch("wrong", expected_hashes.pop_front(), o_hash_value);
                else
                    void'(expected_hashes.pop_front());
            end
            if (hold_request && !hold_used) begin
                // one long hold-off so the engine backs up into the sender
                hold_used   <= 1'b1;
                hold_left   <= HOLD_TICKS;
                i_out_stall <= 1'b1;
            end else if (hold_left != 0) begin
                hold_left   <= hold_left - 1;
                i_out_stall <= 1'b1;
            end else begin
                if (o_out_valid && !i_out_stall) begin
                    if ($urandom_range(0, 31) == 0)
                        rx_paced = !rx_paced;
                    rx_delay = rx_paced ? $urandom_range(0, 5) : 0;
                end else if (rx_delay != 0) begin
                    rx_delay = rx_delay - 1;
                end
                i_out_stall <= (rx_delay != 0);
            end
        end
    end

    // Sequence: reset, directed keys, then random phases under different seeds
    initial begin
        i_rst_n = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        load_seed(32'd0);

        // empty keys, plain and with a maximal length field
        push_word(rand_word(), BYTES_NONE, 31'd0, 1'b1, 1'b1, 0);
        push_word(rand_word(), BYTES_NONE, 31'h7fffffff, 1'b1, 1'b1, 1);
        // single full words at the data extremes
        push_word('1, BYTES_FULL, 31'd8, 1'b1, 1'b1, 0);
        push_word('0, BYTES_FULL, 31'd8, 1'b1, 1'b1, 2);
        // every tail size
        for (int n = 1; n < 8; n++)
            push_word(rand_word(), 4'(n), 31'(n), 1'b1, 1'b1, pick_gap(1'b1));
        // byte counts above eight saturate
        push_word('1, 4'd15, 31'h7fffffff, 1'b1, 1'b1, 0);
        push_word(rand_word(), 4'd9, 31'd8, 1'b1, 1'b1, 0);
        // three-word key ending in a tail
        push_word(rand_word(), BYTES_FULL, 31'd19, 1'b1, 1'b0, 0);
        push_word(rand_word(), BYTES_FULL, 31'd19, 1'b0, 1'b0, 0);
        push_word(rand_word(), 4'd3, 31'd19, 1'b0, 1'b1, 3);
        // zero-count word inside a key is skipped
        push_word(rand_word(), BYTES_FULL, 31'd16, 1'b1, 1'b0, 0);
        push_word(rand_word(), BYTES_NONE, 31'd16, 1'b0, 1'b0, 0);
        push_word(rand_word(), BYTES_FULL, 31'd16, 1'b0, 1'b1, 0);
        // short word before the last one
        push_word(rand_word(), 4'd3, 31'd11, 1'b1, 1'b0, 1);
        push_word(rand_word(), BYTES_FULL, 31'd11, 1'b0, 1'b1, 0);
        // continuing without a first word from the unfinalized hash
        push_word(rand_word(), BYTES_FULL, 31'd0, 1'b0, 1'b1, 0);
        push_word(rand_word(), 4'd5, 31'd0, 1'b0, 1'b0, 0);
        push_word(rand_word(), BYTES_NONE, 31'd0, 1'b0, 1'b1, 0);
        wait_drained();

        load_seed(32'hffffffff);
        random_keys(230);
        wait_drained();

        // receiver hold-off during this phase
        load_seed($urandom);
        hold_request <= 1'b1;
        random_keys(230);
        wait_drained();

        load_seed(32'd1);
        random_keys(230);
        wait_drained();

        load_seed($urandom);
        random_keys(230);
        wait_drained();

        if (mismatch_count == 0 && expected_hashes.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

### sim.f
rtl/mh64_pkg.sv
rtl/mh64_mul.sv
rtl/murmur_hash_64bit.sv
rtl/mh64_checker.sv
sim/testbench.sv
